// ----- sv/iis_pkg.sv -----
// shared constants and types for the integral image stream
`timescale 1ns / 1ps
`default_nettype none
package iis_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int MAX_CHANNELS = 3;

  localparam int CH_SLOTS  = 3;
  localparam int PIX_W     = 8;
  localparam int RUN_W     = 19;
  localparam int AREA_W    = 30;
  localparam int LINE_W    = AREA_W * CH_SLOTS;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_DIM_W = 12;
  localparam int CFG_CH_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = ((PIX_W * CH_SLOTS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((LINE_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(2);

  localparam logic [CFG_DIM_W-1:0] RESET_WIDTH    = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT   = CFG_DIM_W'(480);
  localparam logic [CFG_CH_W-1:0]  RESET_CHANNELS = CFG_CH_W'(1);

  typedef logic [CH_SLOTS-1:0][PIX_W-1:0]  pix_vec_t;
  typedef logic [CH_SLOTS-1:0][AREA_W-1:0] area_vec_t;
  typedef logic [CH_SLOTS-1:0][RUN_W-1:0]  run_vec_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             col_zero;
    logic             row_zero;
    logic             frame_last;
  } tag_t;

endpackage
`default_nettype wire

// ----- sv/integral_image_stream.sv -----
// integral image stream top level: config registers, line store, pipeline
//
// pixels enter on the s_axis channel in raster order, one request per pixel,
// with channel samples c0, c1, c2 packed into tdata from the lowest byte up.
// each request gives one result on m_axis: the summed-area value of every
// channel (30 bits each, inactive channels read zero) and tlast on the last
// pixel of the frame.
// frame width, frame height and channel count are written through the cfg channel
// (index 0, 1, 2); the user must write them only while no pixel is in flight (not
// enforced by the block); cfg_ready is always high. a pixel passes the update
// stage and the output register. throughput: one pixel per clock while
// m_axis_tready is high; the single line store is read on accept and written
// from the update stage. a stalled receiver holds the output register; one more
// pixel is still taken into the update stage, after which s_axis_tready drops
// until the output drains. reset clears the position counters, the row sums and
// the pipeline valid bits and restores 640 x 480 with one channel; the line store
// is not cleared, since every entry is written on the first row before it is read.
`timescale 1ns / 1ps
`default_nettype none
module integral_image_stream (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pixel_c0, pixel_c1, pixel_c2
  input  wire logic [iis_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // area_sum_c0, area_sum_c1, area_sum_c2, zero fill
  output logic [iis_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [iis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [iis_pkg::CFG_DIM_W-1:0]     cfg_data
);

  logic [iis_pkg::CFG_DIM_W-1:0] frame_width;
  logic [iis_pkg::CFG_DIM_W-1:0] frame_height;
  logic [iis_pkg::CFG_CH_W-1:0]  channel_count;

  iis_pkg::tag_t                 tag;
  iis_pkg::pix_vec_t             pix;
  iis_pkg::area_vec_t            out_area;
  logic                          accept;
  logic                          s1_valid;
  logic                          wr_en;
  logic [iis_pkg::COL_W-1:0]     wr_addr;
  logic [iis_pkg::LINE_W-1:0]    wr_data;
  logic [iis_pkg::LINE_W-1:0]    rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= iis_pkg::RESET_WIDTH;
      frame_height  <= iis_pkg::RESET_HEIGHT;
      channel_count <= iis_pkg::RESET_CHANNELS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        iis_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
        end
        iis_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
        end
        iis_pkg::REG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[iis_pkg::CFG_CH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign pix    = s_axis_tdata[iis_pkg::PIX_W*iis_pkg::CH_SLOTS-1:0];
  assign accept = s_axis_tvalid && s_axis_tready;

  iis_pos u_pos (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cfg_width  (frame_width),
    .cfg_height (frame_height),
    .tag        (tag)
  );

  iis_ram #(
    .WIDTH (iis_pkg::LINE_W),
    .DEPTH (iis_pkg::MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (tag.col),
    .rd_data (rd_data)
  );

  iis_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .tag          (tag),
    .pix          (pix),
    .cfg_channels (channel_count),
    .rd_data      (rd_data),
    .out_ready    (m_axis_tready),
    .in_ready     (s_axis_tready),
    .s1_valid     (s1_valid),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_valid    (m_axis_tvalid),
    .out_area     (out_area),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {(iis_pkg::OUT_TDATA_W - iis_pkg::LINE_W)'(0), out_area};

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel missing from the update stage");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && tag.frame_last) |=> (tag.col == '0 && tag.row_zero))
    else $error("position did not wrap after the last pixel of a frame");

  a_write_follows_move: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> m_axis_tvalid)
    else $error("line store written without a result");

endmodule
`default_nettype wire

// ----- sv/iis_ram.sv -----
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module iis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/iis_pos.sv -----
// raster position counters and row / frame end detection
`timescale 1ns / 1ps
`default_nettype none
module iis_pos (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [iis_pkg::CFG_DIM_W-1:0]  cfg_width,
  input  wire logic [iis_pkg::CFG_DIM_W-1:0]  cfg_height,
  output iis_pkg::tag_t                       tag
);

  logic [iis_pkg::COL_W-1:0] column_pos;
  logic [iis_pkg::ROW_W-1:0] row_pos;
  logic [iis_pkg::WID_W-1:0] width_eff;
  logic [iis_pkg::HGT_W-1:0] height_eff;
  logic                      row_last;
  logic                      frame_last;

  always_comb begin
    if (cfg_width == '0) begin
      width_eff = iis_pkg::WID_W'(1);
    end else if (32'(cfg_width) > iis_pkg::MAX_WIDTH) begin
      width_eff = iis_pkg::WID_W'(iis_pkg::MAX_WIDTH);
    end else begin
      width_eff = iis_pkg::WID_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      height_eff = iis_pkg::HGT_W'(1);
    end else if (32'(cfg_height) > iis_pkg::MAX_HEIGHT) begin
      height_eff = iis_pkg::HGT_W'(iis_pkg::MAX_HEIGHT);
    end else begin
      height_eff = iis_pkg::HGT_W'(cfg_height);
    end
  end

  assign row_last   = (iis_pkg::WID_W'(column_pos) + iis_pkg::WID_W'(1)) >= width_eff;
  assign frame_last = row_last &&
                      ((iis_pkg::HGT_W'(row_pos) + iis_pkg::HGT_W'(1)) >= height_eff);

  assign tag.col        = column_pos;
  assign tag.col_zero   = (column_pos == '0);
  assign tag.row_zero   = (row_pos == '0);
  assign tag.frame_last = frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (row_last) begin
        column_pos <= '0;
        row_pos    <= frame_last ? '0 : row_pos + iis_pkg::ROW_W'(1);
      end else begin
        column_pos <= column_pos + iis_pkg::COL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/iis_acc.sv -----
// line store update stage: row running sums, above + run, output register
`timescale 1ns / 1ps
`default_nettype none
module iis_acc (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire iis_pkg::tag_t                 tag,
  input  wire iis_pkg::pix_vec_t             pix,
  input  wire logic [iis_pkg::CFG_CH_W-1:0]  cfg_channels,
  input  wire logic [iis_pkg::LINE_W-1:0]    rd_data,
  input  wire logic                          out_ready,
  output logic                               in_ready,
  output logic                               s1_valid,
  output logic                               wr_en,
  output logic [iis_pkg::COL_W-1:0]          wr_addr,
  output logic [iis_pkg::LINE_W-1:0]         wr_data,
  output logic                               out_valid,
  output iis_pkg::area_vec_t                 out_area,
  output logic                               out_last
);

  iis_pkg::tag_t                 s1_tag;
  iis_pkg::pix_vec_t             s1_pix;
  logic                          s1_fwd;
  logic                          s1_move;
  logic                          accept;
  iis_pkg::area_vec_t            fwd_data;
  iis_pkg::area_vec_t            above;
  iis_pkg::area_vec_t            area;
  iis_pkg::area_vec_t            line_rd;
  iis_pkg::run_vec_t             run;
  iis_pkg::run_vec_t             run_next;
  logic [iis_pkg::CFG_CH_W-1:0]  chans_eff;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;
  assign line_rd  = rd_data;

  always_comb begin
    if (cfg_channels == '0) begin
      chans_eff = iis_pkg::CFG_CH_W'(1);
    end else if (32'(cfg_channels) > iis_pkg::MAX_CHANNELS) begin
      chans_eff = iis_pkg::CFG_CH_W'(iis_pkg::MAX_CHANNELS);
    end else begin
      chans_eff = cfg_channels;
    end
  end

  always_comb begin
    for (int ch = 0; ch < iis_pkg::CH_SLOTS; ch++) begin
      if (s1_tag.row_zero) begin
        above[ch] = '0;
      end else if (s1_fwd) begin
        above[ch] = fwd_data[ch];
      end else begin
        above[ch] = line_rd[ch];
      end
      if (ch < int'(chans_eff)) begin
        run_next[ch] = (s1_tag.col_zero ? '0 : run[ch]) + iis_pkg::RUN_W'(s1_pix[ch]);
        area[ch]     = above[ch] + iis_pkg::AREA_W'(run_next[ch]);
      end else begin
        run_next[ch] = '0;
        area[ch]     = '0;
      end
    end
  end

  assign wr_en   = s1_move;
  assign wr_addr = s1_tag.col;
  assign wr_data = area;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      run       <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
        run       <= run_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // same column written and read in the same cycle only when the row is one pixel wide
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag <= tag;
      s1_pix <= pix;
      s1_fwd <= s1_move && (s1_tag.col == tag.col);
    end
    if (s1_move) begin
      fwd_data <= area;
      out_area <= area;
      out_last <= s1_tag.frame_last;
    end
  end

endmodule
`default_nettype wire
